[design/ckx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckx_pkg: shared types, constants and tables of the k-mer extractor
// Alphabet lookup, c*log2(c) table and register index codes.
// ----------------------------------------------------------------------------
package ckx_pkg;

  localparam int SYMBOL_BITS  = 5;
  localparam int KMER_MAX_DEF = 12;
  localparam int ENT_FRAC_DEF = 16;
  localparam int ALPHA_COUNT  = 20;
  localparam int TABLE_FRAC   = 20;

  // configuration port
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWERCASE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTH_STRANDS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTROPY_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTROPY_HIGH  = 3'd5;

  localparam logic [3:0]  KLEN_RST     = 4'd10;
  localparam logic [16:0] ENT_HIGH_RST = 17'h10000;

  // special bytes
  localparam logic [7:0] CH_GT = 8'h3E;  // header marker
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    ALPHA_NUC   = 2'd0,
    ALPHA_RY    = 2'd1,
    ALPHA_AMINO = 2'd2
  } alpha_mode_e;

  typedef struct packed {
    logic [3:0]  k;      // effective window length
    alpha_mode_e mode;   // normalised alphabet
    logic        lower;  // fold lowercase
  } ckx_cfg_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } sym_t;

  function automatic sym_t lookup(input logic [7:0] ch, input alpha_mode_e mode);
    sym_t s;
    s.hit  = 1'b1;
    s.code = 5'd0;
    case (mode)
      ALPHA_RY: begin
        case (ch)
          "A", "G", "R": s.code = 5'd0;
          "C", "T", "Y": s.code = 5'd1;
          default:       s.hit  = 1'b0;
        endcase
      end
      ALPHA_AMINO: begin
        case (ch)
          "A": s.code = 5'd0;
          "C": s.code = 5'd1;
          "D": s.code = 5'd2;
          "E": s.code = 5'd3;
          "F": s.code = 5'd4;
          "G": s.code = 5'd5;
          "H": s.code = 5'd6;
          "I": s.code = 5'd7;
          "K": s.code = 5'd8;
          "L": s.code = 5'd9;
          "M": s.code = 5'd10;
          "N": s.code = 5'd11;
          "P": s.code = 5'd12;
          "Q": s.code = 5'd13;
          "R": s.code = 5'd14;
          "S": s.code = 5'd15;
          "T": s.code = 5'd16;
          "V": s.code = 5'd17;
          "W": s.code = 5'd18;
          "Y": s.code = 5'd19;
          default: s.hit = 1'b0;
        endcase
      end
      default: begin
        case (ch)
          "A": s.code = 5'd0;
          "C": s.code = 5'd1;
          "G": s.code = 5'd2;
          "T": s.code = 5'd3;
          default: s.hit = 1'b0;
        endcase
      end
    endcase
    return s;
  endfunction

  // c*log2(c) in Q.20
  function automatic int clog_q20(input int c);
    int v;
    case (c)
      2:       v = 2097152;
      3:       v = 4985861;
      4:       v = 8388608;
      5:       v = 12173590;
      6:       v = 16263178;
      7:       v = 20606075;
      8:       v = 25165824;
      9:       v = 29915166;
      10:      v = 34832941;
      11:      v = 39902247;
      12:      v = 45109268;
      default: v = 0;
    endcase
    return v;
  endfunction

  // Q.20 to Q.f, round to nearest
  function automatic int to_frac(input int x, input int f);
    int s;
    s = TABLE_FRAC - f;
    if (s == 0) return x;
    return (x + (1 << (s - 1))) >>> s;
  endfunction

  function automatic int clog_at(input int c, input int f);
    return to_frac(clog_q20(c), f);
  endfunction

  // T[c] - T[c-1]
  function automatic int clog_step(input int c, input int f);
    if (c < 1 || c > 12) return 0;
    return clog_at(c, f) - clog_at(c - 1, f);
  endfunction

  function automatic int log2_alpha(input alpha_mode_e mode, input int f);
    int v;
    case (mode)
      ALPHA_RY:    v = to_frac(1048576, f);
      ALPHA_AMINO: v = to_frac(4531870, f);
      default:     v = to_frac(2097152, f);
    endcase
    return v;
  endfunction

endpackage

[design/ckx_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckx_window: parser, sliding window and symbol counts
// Consumes one byte per advance and registers a full-window candidate.
// ----------------------------------------------------------------------------
module ckx_window #(
  parameter int KMER_MAX = ckx_pkg::KMER_MAX_DEF,
  parameter int ENT_FRAC = ckx_pkg::ENT_FRAC_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ckx_pkg::ckx_cfg_t                       cfg_i,
  input  logic                                    clear_i,
  input  logic                                    adv_i,
  input  logic [7:0]                              byte_i,
  input  logic                                    take_i,
  output logic                                    cand_vld_o,
  output logic [KMER_MAX*ckx_pkg::SYMBOL_BITS-1:0] cand_fwd_o,
  output logic [KMER_MAX*ckx_pkg::SYMBOL_BITS-1:0] cand_rev_o,
  output logic [ENT_FRAC+5:0]                     cand_clog_o
);
  import ckx_pkg::*;

  localparam int WW     = KMER_MAX * SYMBOL_BITS;
  localparam int CW     = $clog2(KMER_MAX + 1);
  localparam int CLOG_W = ENT_FRAC + 6;

  logic              hdr_q, hdr_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     cnt_q [ALPHA_COUNT];
  logic [CW-1:0]     cnt_d [ALPHA_COUNT];
  logic [CW-1:0]     cnt_mid [ALPHA_COUNT];
  logic [CW-1:0]     cnt_new [ALPHA_COUNT];
  logic [CLOG_W-1:0] clog_q, clog_d;
  logic [WW-1:0]     fwd_q, fwd_d, rev_q, rev_d;

  logic              cand_vld_q;
  logic [WW-1:0]     cand_fwd_q, cand_rev_q;
  logic [CLOG_W-1:0] cand_clog_q;

  logic [7:0]        ch;
  sym_t              sym;
  logic [4:0]        comp;
  logic [WW-1:0]     fwd_new, rev_new, fwd_out, rev_out;
  logic [3:0]        k_m1;
  logic [4:0]        oldest;
  logic [CW-1:0]     fill_inc;
  logic              full;
  logic [CLOG_W-1:0] up_sum, dn_sum, clog_inc;
  logic              emit;

  // symbol decode and window shift
  always_comb begin
    ch = byte_i;
    if (cfg_i.lower && (byte_i inside {[CH_LA:CH_LZ]})) begin
      ch = byte_i - CASE_OFS;
    end
    sym = lookup(ch, cfg_i.mode);
    case (cfg_i.mode)
      ALPHA_RY:    comp = 5'd1 - sym.code;
      ALPHA_AMINO: comp = sym.code;
      default:     comp = 5'd3 - sym.code;
    endcase
    fwd_new  = (fwd_q << SYMBOL_BITS) | WW'(sym.code);
    rev_new  = (rev_q >> SYMBOL_BITS) | (WW'(comp) << (WW - SYMBOL_BITS));
    k_m1     = cfg_i.k - 4'd1;
    fill_inc = fill_q + CW'(1);
    full     = 4'(fill_inc) >= cfg_i.k;
    oldest   = '0;
    fwd_out  = '0;
    rev_out  = '0;
    for (int j = 0; j < KMER_MAX; j++) begin
      if (4'(j) == k_m1) oldest = fwd_new[j*SYMBOL_BITS +: SYMBOL_BITS];
      if (4'(j) < cfg_i.k) fwd_out[j*SYMBOL_BITS +: SYMBOL_BITS] =
                             fwd_new[j*SYMBOL_BITS +: SYMBOL_BITS];
      if (4'(KMER_MAX - j) == cfg_i.k) rev_out = rev_new >> (SYMBOL_BITS * j);
    end
  end

  // count lanes: each lane looks up its own table step, one-hot select
  always_comb begin
    up_sum = '0;
    dn_sum = '0;
    for (int i = 0; i < ALPHA_COUNT; i++) begin
      cnt_mid[i] = cnt_q[i] + CW'(sym.code == 5'(i));
      cnt_new[i] = cnt_mid[i] - CW'(full && (oldest == 5'(i)));
      if (sym.code == 5'(i)) begin
        up_sum = up_sum | CLOG_W'(clog_step(int'(cnt_q[i]) + 1, ENT_FRAC));
      end
      if (full && (oldest == 5'(i))) begin
        dn_sum = dn_sum | CLOG_W'(clog_step(int'(cnt_mid[i]), ENT_FRAC));
      end
    end
    clog_inc = clog_q + up_sum;
  end

  // next state
  always_comb begin
    hdr_d  = hdr_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    clog_d = clog_q;
    fwd_d  = fwd_q;
    rev_d  = rev_q;
    emit   = 1'b0;
    if (clear_i) begin
      fill_d = '0;
      cnt_d  = '{default: '0};
      clog_d = '0;
      fwd_d  = '0;
      rev_d  = '0;
    end else if (adv_i) begin
      if (byte_i == CH_GT) begin
        hdr_d  = 1'b1;
        fill_d = '0;
        cnt_d  = '{default: '0};
        clog_d = '0;
        fwd_d  = '0;
        rev_d  = '0;
      end else if (hdr_q) begin
        if (byte_i == CH_NL) hdr_d = 1'b0;
      end else if (byte_i != CH_NL) begin
        if (!sym.hit) begin
          fill_d = '0;
          cnt_d  = '{default: '0};
          clog_d = '0;
          fwd_d  = '0;
          rev_d  = '0;
        end else begin
          fwd_d  = fwd_new;
          rev_d  = rev_new;
          cnt_d  = cnt_new;
          clog_d = clog_inc - dn_sum;
          fill_d = full ? CW'(k_m1) : fill_inc;
          emit   = full;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q      <= 1'b0;
      fill_q     <= '0;
      cnt_q      <= '{default: '0};
      clog_q     <= '0;
      fwd_q      <= '0;
      rev_q      <= '0;
      cand_vld_q <= 1'b0;
    end else begin
      hdr_q  <= hdr_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      clog_q <= clog_d;
      fwd_q  <= fwd_d;
      rev_q  <= rev_d;
      if (adv_i) begin
        cand_vld_q <= emit;
      end else if (take_i) begin
        cand_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && emit) begin
      cand_fwd_q  <= fwd_out;
      cand_rev_q  <= rev_out;
      cand_clog_q <= clog_inc;
    end
  end

  assign cand_vld_o  = cand_vld_q;
  assign cand_fwd_o  = cand_fwd_q;
  assign cand_rev_o  = cand_rev_q;
  assign cand_clog_o = cand_clog_q;

  a_fill_below_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    4'(fill_q) < cfg_i.k)
    else $error("fill count reached window length");

  a_marker_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && byte_i == CH_GT |=> hdr_q && fill_q == '0 && clog_q == '0)
    else $error("header marker did not clear window");

endmodule

[design/ckx_entropy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckx_entropy: entropy band check
// Bounds are turned into products with the denominator, so no divider.
// ----------------------------------------------------------------------------
module ckx_entropy #(
  parameter int KMER_MAX = ckx_pkg::KMER_MAX_DEF,
  parameter int ENT_FRAC = ckx_pkg::ENT_FRAC_DEF
) (
  input  logic                 clk_i,
  input  ckx_pkg::ckx_cfg_t    cfg_i,
  input  logic [16:0]          low_i,
  input  logic [16:0]          high_i,
  input  logic [ENT_FRAC+5:0]  clog_i,
  output logic                 pass_o
);
  import ckx_pkg::*;

  localparam int CLOG_W = ENT_FRAC + 6;
  localparam int E_W    = ENT_FRAC + 2;   // bound in entropy units
  localparam int D_W    = ENT_FRAC + 3 + $clog2(KMER_MAX + 1);   // k * log2(A)
  localparam int P_W    = E_W + D_W;
  localparam int SHL    = (ENT_FRAC >= 16) ? ENT_FRAC - 16 : 0;
  localparam int SHR    = (ENT_FRAC < 16) ? 16 - ENT_FRAC : 0;
  localparam int TW     = 18 + SHL;
  localparam logic [E_W-1:0] E_ONE = {2'b01, {ENT_FRAC{1'b0}}};

  logic [TW-1:0]     lo_t, hi_t;
  logic [E_W-1:0]    lo_e, hi_e;
  logic [D_W-1:0]    den_q;
  logic [P_W-1:0]    lo_prod_q, hi_prod_q;
  logic              lo_ok_q, hi_all_q;
  logic [CLOG_W-1:0] topk_q;
  logic [CLOG_W-1:0] num;
  logic [P_W-1:0]    num_sh;

  // e >= low and e <= high as bounds on the integer quotient
  always_comb begin
    lo_t = ((TW'(low_i) + TW'((1 << SHR) - 1)) << SHL) >> SHR;
    hi_t = (TW'(high_i) << SHL) >> SHR;
    lo_e = E_W'(lo_t);
    hi_e = E_W'(hi_t);
  end

  always_ff @(posedge clk_i) begin
    den_q     <= D_W'(int'(cfg_i.k) * log2_alpha(cfg_i.mode, ENT_FRAC));
    topk_q    <= CLOG_W'(clog_at(int'(cfg_i.k), ENT_FRAC));
    lo_ok_q   <= lo_e <= E_ONE;
    hi_all_q  <= hi_e >= E_ONE;
    lo_prod_q <= P_W'(lo_e) * P_W'(den_q);
    hi_prod_q <= (P_W'(hi_e) + P_W'(1)) * P_W'(den_q);
  end

  always_comb begin
    num    = (topk_q > clog_i) ? topk_q - clog_i : '0;
    num_sh = P_W'(num) << ENT_FRAC;
    pass_o = lo_ok_q && (num_sh >= lo_prod_q) && (hi_all_q || (num_sh < hi_prod_q));
  end

endmodule

[design/canonical_kmer_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_kmer_extractor: canonical k-mers from FASTA text
// Byte stream in, packed k-mer words out, one byte per clock while the output side takes words.
// ----------------------------------------------------------------------------
// Takes one FASTA byte per clock and returns at most one k-mer word per byte.
// The byte passes three registers: input register, window/candidate register
// (parser, symbol counts and running c*log2(c) sum all update in that one
// step), then the entropy check and strand choice into the output register.
// Sustained rate is one byte per cycle for as long as the output side takes
// words. Bytes that yield no word (headers, newlines, windows not yet full or
// outside the entropy band) simply leave no result. The band limits are held
// as precomputed products with k*log2(A); after a write to kmer_length,
// alphabet_mode or the entropy limits they settle through the k*log2(A)
// register and the product registers. Writes to kmer_length or
// alphabet_mode also empty the window. There is no clearing pass after
// reset; words are taken from the first clock.
// ----------------------------------------------------------------------------
module canonical_kmer_extractor #(
  parameter int KMER_MAX          = ckx_pkg::KMER_MAX_DEF,
  parameter int ENTROPY_FRAC_BITS = ckx_pkg::ENT_FRAC_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // configuration
  input  logic                                     cfg_we_i,
  input  logic [ckx_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [ckx_pkg::CFG_W-1:0]                cfg_wdata_i,
  // text in
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [7:0]                               text_byte_i,
  // k-mers out
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [KMER_MAX*ckx_pkg::SYMBOL_BITS-1:0] kmer_code_o,
  output logic                                     took_reverse_o
);
  import ckx_pkg::*;

  localparam int WW     = KMER_MAX * SYMBOL_BITS;
  localparam int CLOG_W = ENTROPY_FRAC_BITS + 6;

  // configuration registers
  logic [3:0]  kmer_length_q;
  logic [1:0]  alphabet_mode_q;
  logic        lowercase_q;
  logic        both_strands_q;
  logic [16:0] entropy_low_q;
  logic [16:0] entropy_high_q;
  ckx_cfg_t    cfg;
  logic        shape_clear;

  // stage registers
  logic        byte_vld_q;
  logic [7:0]  byte_q;
  logic        out_vld_q;
  logic [WW-1:0] out_code_q;
  logic        out_rev_q;

  // pipeline control
  logic        out_ready, cand_ready, cand_take, byte_adv, in_take;
  logic        cand_vld;
  logic [WW-1:0]     cand_fwd, cand_rev;
  logic [CLOG_W-1:0] cand_clog;
  logic        pass;
  logic        flip;

  // ---- configuration -------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q   <= KLEN_RST;
      alphabet_mode_q <= ALPHA_NUC;
      lowercase_q     <= 1'b0;
      both_strands_q  <= 1'b1;
      entropy_low_q   <= '0;
      entropy_high_q  <= ENT_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KMER_LENGTH:   kmer_length_q   <= cfg_wdata_i[3:0];
        CFG_ALPHABET_MODE: alphabet_mode_q <= cfg_wdata_i[1:0];
        CFG_LOWERCASE:     lowercase_q     <= cfg_wdata_i[0];
        CFG_BOTH_STRANDS:  both_strands_q  <= cfg_wdata_i[0];
        CFG_ENTROPY_LOW:   entropy_low_q   <= cfg_wdata_i;
        CFG_ENTROPY_HIGH:  entropy_high_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // shape change empties the window
  assign shape_clear = cfg_we_i &&
                       (cfg_index_i == CFG_KMER_LENGTH || cfg_index_i == CFG_ALPHABET_MODE);

  // effective length (0 acts as 1, clamp to KMER_MAX); mode 3 acts as ACGT
  always_comb begin
    if (kmer_length_q == 4'd0) begin
      cfg.k = 4'd1;
    end else if (kmer_length_q > 4'(KMER_MAX)) begin
      cfg.k = 4'(KMER_MAX);
    end else begin
      cfg.k = kmer_length_q;
    end
    case (alphabet_mode_q)
      ALPHA_RY:    cfg.mode = ALPHA_RY;
      ALPHA_AMINO: cfg.mode = ALPHA_AMINO;
      default:     cfg.mode = ALPHA_NUC;
    endcase
    cfg.lower = lowercase_q;
  end

  // ---- handshake -----------------------------------------------------------
  // Each stage frees itself when empty or when its word moves on, so bubbles
  // are squeezed out while a finished word waits at the output.
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign cand_take  = cand_vld && out_ready;
  assign cand_ready = !cand_vld || out_ready;
  assign byte_adv   = byte_vld_q && cand_ready;
  assign in_stall_o = byte_vld_q && !cand_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_take) begin
      byte_vld_q <= 1'b1;
    end else if (byte_adv) begin
      byte_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) byte_q <= text_byte_i;
  end

  // ---- window and counts ---------------------------------------------------
  ckx_window #(
    .KMER_MAX (KMER_MAX),
    .ENT_FRAC (ENTROPY_FRAC_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .clear_i     (shape_clear),
    .adv_i       (byte_adv),
    .byte_i      (byte_q),
    .take_i      (cand_take),
    .cand_vld_o  (cand_vld),
    .cand_fwd_o  (cand_fwd),
    .cand_rev_o  (cand_rev),
    .cand_clog_o (cand_clog)
  );

  // ---- entropy band --------------------------------------------------------
  ckx_entropy #(
    .KMER_MAX (KMER_MAX),
    .ENT_FRAC (ENTROPY_FRAC_BITS)
  ) u_entropy (
    .clk_i  (clk_i),
    .cfg_i  (cfg),
    .low_i  (entropy_low_q),
    .high_i (entropy_high_q),
    .clog_i (cand_clog),
    .pass_o (pass)
  );

  // ---- strand choice and output register -----------------------------------
  // reverse complement wins only when strictly smaller; never for amino acids
  assign flip = both_strands_q && (cfg.mode != ALPHA_AMINO) && (cand_rev < cand_fwd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cand_take) begin
      out_vld_q <= pass;
    end else if (out_ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_take) begin
      out_code_q <= flip ? cand_rev : cand_fwd;
      out_rev_q  <= flip;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kmer_code_o    = out_code_q;
  assign took_reverse_o = out_rev_q;

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output word");

  a_word_from_candidate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cand_vld))
    else $error("output word appeared without a candidate");

endmodule

[test/ckx_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckx_checker: k-mer word scoreboard for the canonical k-mer extractor
// Follows register writes and accepted text bytes, predicts the k-mer words
// that must leave the block and compares each accepted output word with them.
// ----------------------------------------------------------------------------
module ckx_checker (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               cfg_we_i,
  input  logic [ckx_pkg::CFG_IDX_W-1:0]                      cfg_index_i,
  input  logic [ckx_pkg::CFG_W-1:0]                          cfg_wdata_i,
  input  logic                                               in_valid_i,
  input  logic                                               in_stall_i,
  input  logic [7:0]                                         text_byte_i,
  input  logic                                               out_valid_i,
  input  logic                                               out_stall_i,
  input  logic [ckx_pkg::KMER_MAX_DEF*ckx_pkg::SYMBOL_BITS-1:0] kmer_code_i,
  input  logic                                               took_reverse_i,
  input  logic                                               end_check_i,
  output int                                                 mismatches_o,
  output int                                                 words_due_o
);

  import ckx_pkg::*;

  localparam int KMAX  = KMER_MAX_DEF;
  localparam int WIN_W = KMAX * SYMBOL_BITS;
  localparam logic [8*ALPHA_COUNT-1:0] AMINO_ORDER = "ACDEFGHIKLMNPQRSTVWY";

  typedef struct packed {
    logic [WIN_W-1:0] kmer;
    logic             rev;
  } kmer_word_t;

  // register copies
  logic [3:0]        klen_q;
  logic [1:0]        mode_q;
  logic              fold_q;
  logic              both_q;
  logic [16:0]       ent_lo_q;
  logic [16:0]       ent_hi_q;

  // window state
  logic              in_header_q;
  logic [WIN_W-1:0]  fwd_win_q;
  logic [WIN_W-1:0]  rev_win_q;
  int unsigned       fill_q;
  int unsigned       sym_cnt [ALPHA_COUNT];

  kmer_word_t        pending_kmers [$];
  kmer_word_t        head_w;

  // Q.20 to Q.ENT_FRAC_DEF, round to nearest
  function automatic longint unsigned to_q(input longint unsigned x);
    int sh;
    sh = TABLE_FRAC - ENT_FRAC_DEF;
    if (sh == 0) return x;
    return (x + (longint'(1) << (sh - 1))) >> sh;
  endfunction

  function automatic longint unsigned clog(input int unsigned c);
    longint unsigned v;
    case (c)
      2:       v = 2097152;
      3:       v = 4985861;
      4:       v = 8388608;
      5:       v = 12173590;
      6:       v = 16263178;
      7:       v = 20606075;
      8:       v = 25165824;
      9:       v = 29915166;
      10:      v = 34832941;
      11:      v = 39902247;
      12:      v = 45109268;
      default: v = 0;
    endcase
    return to_q(v);
  endfunction

  function automatic int unsigned window_len();
    if (klen_q == 0) return 1;
    if (klen_q > KMAX) return KMAX;
    return klen_q;
  endfunction

  // symbol code, or -1 for a byte outside the alphabet
  function automatic int symbol_of(input logic [7:0] ch);
    int i;
    case (mode_q)
      ALPHA_RY: begin
        if (ch == "A" || ch == "G" || ch == "R") return 0;
        if (ch == "C" || ch == "T" || ch == "Y") return 1;
        return -1;
      end
      ALPHA_AMINO: begin
        for (i = 0; i < ALPHA_COUNT; i++)
          if (AMINO_ORDER[8*(ALPHA_COUNT-1-i) +: 8] == ch) return i;
        return -1;
      end
      default: begin
        if (ch == "A") return 0;
        if (ch == "C") return 1;
        if (ch == "G") return 2;
        if (ch == "T") return 3;
        return -1;
      end
    endcase
  endfunction

  function automatic bit entropy_in_band(input int unsigned k);
    longint unsigned csum, top, num, den, ent, one;
    int i;
    csum = 0;
    for (i = 0; i < ALPHA_COUNT; i++) csum += clog(sym_cnt[i]);
    top = clog(k);
    num = (top > csum) ? top - csum : 0;
    case (mode_q)
      ALPHA_RY:    den = k * to_q(1048576);
      ALPHA_AMINO: den = k * to_q(4531870);
      default:     den = k * to_q(2097152);
    endcase
    one = longint'(1) << ENT_FRAC_DEF;
    ent = (den != 0) ? (num << ENT_FRAC_DEF) / den : 0;
    if (ent > one) ent = one;
    return (ent * 65536 >= ent_lo_q * one) && (ent * 65536 <= ent_hi_q * one);
  endfunction

  task automatic clear_window();
    int i;
    fwd_win_q = '0;
    rev_win_q = '0;
    fill_q    = 0;
    for (i = 0; i < ALPHA_COUNT; i++) sym_cnt[i] = 0;
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      CFG_KMER_LENGTH:   begin klen_q = val[3:0]; clear_window(); end
      CFG_ALPHABET_MODE: begin mode_q = val[1:0]; clear_window(); end
      CFG_LOWERCASE:     fold_q = val[0];
      CFG_BOTH_STRANDS:  both_q = val[0];
      CFG_ENTROPY_LOW:   ent_lo_q = val;
      CFG_ENTROPY_HIGH:  ent_hi_q = val;
      default: ;
    endcase
  endtask

  // slides one byte into the window and queues the word it yields, if any
  task automatic advance_window(input logic [7:0] b);
    logic [7:0]       ch;
    logic [WIN_W-1:0] mask, fwd, rev;
    int               code;
    int unsigned      comp, k, oldest;
    kmer_word_t       w;
    ch = b;
    if (ch == CH_GT) begin
      in_header_q = 1'b1;
      clear_window();
      return;
    end
    if (in_header_q) begin
      if (ch == CH_NL) in_header_q = 1'b0;
      return;
    end
    if (ch == CH_NL) return;
    if (fold_q && ch >= CH_LA && ch <= CH_LZ) ch = ch - CASE_OFS;
    code = symbol_of(ch);
    if (code < 0) begin
      clear_window();
      return;
    end
    case (mode_q)
      ALPHA_RY:    comp = 1 - code;
      ALPHA_AMINO: comp = code;
      default:     comp = 3 - code;
    endcase
    k = window_len();
    fwd_win_q = {fwd_win_q[WIN_W-SYMBOL_BITS-1:0], 5'(code)};
    rev_win_q = {5'(comp), rev_win_q[WIN_W-1:SYMBOL_BITS]};
    if (sym_cnt[code] < KMAX) sym_cnt[code]++;
    fill_q++;
    if (fill_q < k) return;
    if (entropy_in_band(k)) begin
      mask = '1;
      mask = mask >> (WIN_W - SYMBOL_BITS * k);
      fwd = fwd_win_q & mask;
      rev = rev_win_q >> (SYMBOL_BITS * (KMAX - k));
      w.kmer = fwd;
      w.rev  = 1'b0;
      if (both_q && mode_q != ALPHA_AMINO && fwd > rev) begin
        w.kmer = rev;
        w.rev  = 1'b1;
      end
      pending_kmers.insert(pending_kmers.size(), w);
    end
    fwd = fwd_win_q >> (SYMBOL_BITS * (k - 1));
    oldest = fwd[4:0];
    if (oldest < ALPHA_COUNT && sym_cnt[oldest] > 0) sym_cnt[oldest]--;
    fill_q = k - 1;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("%0t ckx_checker: %s", $time, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q       = KLEN_RST;
      mode_q       = ALPHA_NUC;
      fold_q       = 1'b0;
      both_q       = 1'b1;
      ent_lo_q     = '0;
      ent_hi_q     = ENT_HIGH_RST;
      in_header_q  = 1'b0;
      clear_window();
      pending_kmers.delete();
      mismatches_o = 0;
      words_due_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_kmers.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %h rev %0b", kmer_code_i, took_reverse_i));
        end else begin
          head_w = pending_kmers.pop_front();
          if (kmer_code_i !== head_w.kmer)
            flag_mismatch($sformatf("kmer_code %h, want %h", kmer_code_i, head_w.kmer));
          if (took_reverse_i !== head_w.rev)
            flag_mismatch($sformatf("took_reverse %b, want %b for %h",
                                    took_reverse_i, head_w.rev, head_w.kmer));
        end
      end
      if (cfg_we_i) apply_cfg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) advance_window(text_byte_i);
      if (end_check_i) begin
        while (pending_kmers.size() != 0) begin
          head_w = pending_kmers.pop_front();
          flag_mismatch($sformatf("word %h rev %0b never arrived", head_w.kmer, head_w.rev));
        end
      end
      words_due_o = pending_kmers.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the canonical k-mer extractor
// Feeds FASTA-like byte streams under a sweep of register settings and
// random back-pressure; ckx_checker predicts and compares every k-mer word.
// ----------------------------------------------------------------------------
module tb_top;

  import ckx_pkg::*;

  localparam int         KW              = KMER_MAX_DEF * SYMBOL_BITS;
  localparam logic [1:0] ALPHA_SPARE     = 2'd3;     // unused mode code, decodes as ACGT
  localparam logic [7:0] CH_CR           = 8'h0D;
  localparam int         SEGMENT_SYMBOLS = 128;      // symbol bytes per random segment
  localparam int         DRAIN_CYCLES    = 6;        // 3-stage pipe plus band settle

  localparam logic [8*4-1:0]  NUC_SET   = "ACGT";
  localparam logic [8*6-1:0]  RY_SET    = "ACGTRY";
  localparam logic [8*20-1:0] AMINO_SET = "ACDEFGHIKLMNPQRSTVWY";

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [7:0]           text_byte    = 8'h00;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [KW-1:0]        kmer_code;
  logic                 took_reverse;
  logic                 end_check    = 1'b0;
  int                   mismatches;
  int                   words_due;

  // idle rates in percent, changed only between segments
  int                   send_idle_pct = 30;
  int                   recv_idle_pct = 54;

  always #5 clk = ~clk;

  canonical_kmer_extractor dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .text_byte_i    (text_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kmer_code_o    (kmer_code),
    .took_reverse_o (took_reverse)
  );

  ckx_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .text_byte_i    (text_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .kmer_code_i    (kmer_code),
    .took_reverse_i (took_reverse),
    .end_check_i    (end_check),
    .mismatches_o   (mismatches),
    .words_due_o    (words_due)
  );

  // Output back-pressure: a fresh roll every cycle, driven on the falling edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_idle_pct);
  end

  // One text byte. Called on a falling edge, returns on a falling edge with
  // valid still high, so back-to-back words need no extra assignment.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    text_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Header line of random printable bytes; a '>' inside it is fine and
  // simply restarts the header.
  task automatic send_header();
    int n, i;
    n = $urandom_range(6);
    send_byte(CH_GT);
    for (i = 0; i < n; i++) send_byte(8'($urandom_range(126, 32)));
    send_byte(CH_NL);
  endtask

  // Wait for every predicted word, then let the pipe and band limits settle,
  // so that register writes land on an idle block.
  task automatic settle_idle();
    in_valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[CFG_W-1:0];
    @(negedge clk);
  endtask

  function automatic logic [7:0] letter_of(input logic [1:0] mode, input int idx);
    case (mode)
      ALPHA_RY:    return RY_SET[8*(5-idx) +: 8];
      ALPHA_AMINO: return AMINO_SET[8*(19-idx) +: 8];
      default:     return NUC_SET[8*(3-idx) +: 8];
    endcase
  endfunction

  // Well-formed FASTA with random content. Letters come from a window of
  // 'spread' symbols so that narrow spreads give low-complexity stretches.
  // A few percent of bytes are raw noise, lowercase slips or extra headers.
  task automatic send_segment(input logic [1:0] mode, input bit fold, input int spread);
    int         sent, len, base, roll;
    logic [7:0] ch;
    case (mode)
      ALPHA_RY:    len = 6;
      ALPHA_AMINO: len = 20;
      default:     len = 4;
    endcase
    base = $urandom_range(len - 1);
    sent = 0;
    send_header();
    while (sent < SEGMENT_SYMBOLS) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        send_header();
      end else if (roll < 6) begin
        send_byte(CH_NL);
      end else begin
        if (roll < 9) begin
          ch = 8'($urandom_range(255));
        end else begin
          ch = letter_of(mode, (base + $urandom_range(spread - 1)) % len);
          if ((fold && $urandom_range(99) < 30) || $urandom_range(99) < 2)
            ch = ch + CASE_OFS;
        end
        send_byte(ch);
        sent++;
      end
    end
  endtask

  // One register setting plus one random segment. Segments 0-3 stall the
  // output hardest, 4-7 starve the input, 8-11 run flat out.
  task automatic run_segment(input int seg, input int k, input logic [1:0] mode,
                             input bit fold, input bit both, input int lo,
                             input int hi, input int spread);
    settle_idle();
    send_idle_pct = (seg < 4) ? 30 : ((seg < 8) ? 54 : 0);
    recv_idle_pct = (seg < 4) ? 54 : ((seg < 8) ? 30 : 0);
    write_reg(CFG_KMER_LENGTH, k);
    write_reg(CFG_ALPHABET_MODE, 32'(mode));
    write_reg(CFG_LOWERCASE, 32'(fold));
    write_reg(CFG_BOTH_STRANDS, 32'(both));
    write_reg(CFG_ENTROPY_LOW, lo);
    write_reg(CFG_ENTROPY_HIGH, hi);
    cfg_we = 1'b0;
    send_segment(mode, fold, spread);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: 3-mers over ACGT, both strands, full band.
    write_reg(CFG_KMER_LENGTH, 3);
    write_reg(CFG_ALPHABET_MODE, 32'(ALPHA_NUC));
    write_reg(CFG_LOWERCASE, 0);
    write_reg(CFG_BOTH_STRANDS, 1);
    write_reg(CFG_ENTROPY_LOW, 0);
    write_reg(CFG_ENTROPY_HIGH, 32'(ENT_HIGH_RST));
    cfg_we = 1'b0;
    // byte extremes, nested header marker, newline inside the sequence
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text(">A>C\nACG\nT");
    // zero-entropy band only: the window is kept across this write
    settle_idle();
    write_reg(CFG_ENTROPY_HIGH, 0);
    cfg_we = 1'b0;
    send_text("TTT");
    // back to the full band, lowercase folding on; carriage return clears
    settle_idle();
    write_reg(CFG_ENTROPY_HIGH, 32'(ENT_HIGH_RST));
    write_reg(CFG_LOWERCASE, 1);
    cfg_we = 1'b0;
    send_text("a");
    send_byte(CH_CR);
    send_text("cgt");

    // Random sweep over lengths (incl. 0 and 15), modes (incl. the spare
    // code) and entropy bands from zero-only to wider than full.
    run_segment(0,  10, ALPHA_NUC,   0, 1, 0,     65536,  4);
    run_segment(1,  1,  ALPHA_RY,    1, 1, 0,     65536,  2);
    run_segment(2,  12, ALPHA_AMINO, 1, 1, 0,     65536,  20);
    run_segment(3,  0,  ALPHA_SPARE, 0, 0, 0,     65536,  4);
    run_segment(4,  15, ALPHA_NUC,   1, 1, 32768, 65536,  4);
    run_segment(5,  5,  ALPHA_RY,    0, 0, 0,     40000,  2);
    run_segment(6,  7,  ALPHA_AMINO, 0, 0, 20000, 131071, 6);
    run_segment(7,  4,  ALPHA_NUC,   1, 1, 0,     0,      2);
    run_segment(8,  4,  ALPHA_NUC,   0, 1, 65536, 65536,  4);
    run_segment(9,  12, ALPHA_NUC,   1, 1, 0,     65536,  4);
    run_segment(10, 2,  ALPHA_AMINO, 1, 0, 0,     65536,  20);
    run_segment(11, 9,  ALPHA_RY,    1, 1, 10000, 60000,  2);

    settle_idle();
    end_check = 1'b1;
    @(negedge clk);
    end_check = 1'b0;
    @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: fires far beyond the end of the slowest correct run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[canonical_kmer_extractor.f]
design/ckx_pkg.sv
design/ckx_window.sv
design/ckx_entropy.sv
design/canonical_kmer_extractor.sv
test/ckx_checker.sv
test/tb_top.sv
